[hdl/alm_pkg.sv]
`default_nettype none

package alm_pkg;

    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_COEF_WIDTH   = 32;

    localparam int MS_GUARD = 10;
    localparam int LV_GUARD = 16;

    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;
    localparam int HOLD_TIME_W  = 24;
    localparam int CLIP_LEVEL_W = 24;
    localparam int COUNT_W      = 32;

    localparam logic [31:0] RST_SHORT_COEF      = 32'd298244;
    localparam logic [31:0] RST_LONG_COEF       = 32'd29826;
    localparam logic [31:0] RST_PEAK_COEF       = 32'd298244;
    localparam logic [31:0] RST_HOLD_DECAY_COEF = 32'd59652;
    localparam logic [HOLD_TIME_W-1:0]  RST_HOLD_TIME  = 24'd48000;
    localparam logic [CLIP_LEVEL_W-1:0] RST_CLIP_LEVEL = 24'd8388607;

    typedef struct packed {
        logic [31:0]             short_coef;
        logic [31:0]             long_coef;
        logic [31:0]             peak_coef;
        logic [31:0]             hold_decay_coef;
        logic [HOLD_TIME_W-1:0]  hold_time;
        logic [CLIP_LEVEL_W-1:0] clip_level;
    } cfg_t;

    typedef enum logic [2:0] {
        DP_LOAD   = 3'd0,
        DP_SQUARE = 3'd1,
        DP_SELECT = 3'd2,
        DP_MUL    = 3'd3,
        DP_ACC    = 3'd4,
        DP_APPLY  = 3'd5,
        DP_EMIT   = 3'd6
    } dp_op_t;

    typedef enum logic [1:0] {
        UNIT_SHORT = 2'd0,
        UNIT_LONG  = 2'd1,
        UNIT_PEAK  = 2'd2,
        UNIT_HOLD  = 2'd3
    } unit_t;

    typedef struct packed {
        dp_op_t op;
        unit_t  unit;
        logic   go;
    } ctrl_t;

endpackage

`default_nettype wire

[hdl/alm_regs.sv]
`default_nettype none

module alm_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [alm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [alm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [alm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output alm_pkg::cfg_t                       cfg
);
    import alm_pkg::*;

    localparam logic [2:0] REG_SHORT_COEF      = 3'd0;
    localparam logic [2:0] REG_LONG_COEF       = 3'd1;
    localparam logic [2:0] REG_PEAK_COEF       = 3'd2;
    localparam logic [2:0] REG_HOLD_DECAY_COEF = 3'd3;
    localparam logic [2:0] REG_HOLD_TIME       = 3'd4;
    localparam logic [2:0] REG_CLIP_LEVEL      = 3'd5;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SHORT_COEF:      cfg_next.short_coef      = pwdata;
                REG_LONG_COEF:       cfg_next.long_coef       = pwdata;
                REG_PEAK_COEF:       cfg_next.peak_coef       = pwdata;
                REG_HOLD_DECAY_COEF: cfg_next.hold_decay_coef = pwdata;
                REG_HOLD_TIME:       cfg_next.hold_time       = pwdata[HOLD_TIME_W-1:0];
                REG_CLIP_LEVEL:      cfg_next.clip_level      = pwdata[CLIP_LEVEL_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SHORT_COEF:      prdata = cfg_reg.short_coef;
            REG_LONG_COEF:       prdata = cfg_reg.long_coef;
            REG_PEAK_COEF:       prdata = cfg_reg.peak_coef;
            REG_HOLD_DECAY_COEF: prdata = cfg_reg.hold_decay_coef;
            REG_HOLD_TIME:       prdata = CFG_DATA_W'(cfg_reg.hold_time);
            REG_CLIP_LEVEL:      prdata = CFG_DATA_W'(cfg_reg.clip_level);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_coef      <= RST_SHORT_COEF;
            cfg_reg.long_coef       <= RST_LONG_COEF;
            cfg_reg.peak_coef       <= RST_PEAK_COEF;
            cfg_reg.hold_decay_coef <= RST_HOLD_DECAY_COEF;
            cfg_reg.hold_time       <= RST_HOLD_TIME;
            cfg_reg.clip_level      <= RST_CLIP_LEVEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hdl/alm_sequencer.sv]
`default_nettype none

module alm_sequencer #(
    parameter int NUM_CHUNKS = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic sample_valid,
    input  wire logic result_busy,
    output alm_pkg::ctrl_t ctrl
);
    import alm_pkg::*;

    localparam int PC_W  = 5;
    localparam int CNT_W = $clog2(NUM_CHUNKS + 1);

    typedef enum logic [1:0] {
        JC_NONE     = 2'd0,
        JC_NO_INPUT = 2'd1,
        JC_LOOP     = 2'd2,
        JC_OUT_BUSY = 2'd3
    } jcond_t;

    typedef struct packed {
        dp_op_t          op;
        unit_t           unit;
        jcond_t          jc;
        logic [PC_W-1:0] target;
    } uinstr_t;

    localparam logic [PC_W-1:0] ST_WAIT       = 5'd0;
    localparam logic [PC_W-1:0] ST_SQUARE     = 5'd1;
    localparam logic [PC_W-1:0] ST_SHORT_SEL  = 5'd2;
    localparam logic [PC_W-1:0] ST_SHORT_MUL  = 5'd3;
    localparam logic [PC_W-1:0] ST_SHORT_ACC  = 5'd4;
    localparam logic [PC_W-1:0] ST_SHORT_APP  = 5'd5;
    localparam logic [PC_W-1:0] ST_LONG_SEL   = 5'd6;
    localparam logic [PC_W-1:0] ST_LONG_MUL   = 5'd7;
    localparam logic [PC_W-1:0] ST_LONG_ACC   = 5'd8;
    localparam logic [PC_W-1:0] ST_LONG_APP   = 5'd9;
    localparam logic [PC_W-1:0] ST_PEAK_SEL   = 5'd10;
    localparam logic [PC_W-1:0] ST_PEAK_MUL   = 5'd11;
    localparam logic [PC_W-1:0] ST_PEAK_ACC   = 5'd12;
    localparam logic [PC_W-1:0] ST_PEAK_APP   = 5'd13;
    localparam logic [PC_W-1:0] ST_HOLD_SEL   = 5'd14;
    localparam logic [PC_W-1:0] ST_HOLD_MUL   = 5'd15;
    localparam logic [PC_W-1:0] ST_HOLD_ACC   = 5'd16;
    localparam logic [PC_W-1:0] ST_HOLD_APP   = 5'd17;
    localparam logic [PC_W-1:0] ST_EMIT       = 5'd18;

    function automatic uinstr_t rom(input logic [PC_W-1:0] addr);
        uinstr_t w;
        case (addr)
            ST_WAIT:      w = '{DP_LOAD,   UNIT_SHORT, JC_NO_INPUT, ST_WAIT};
            ST_SQUARE:    w = '{DP_SQUARE, UNIT_SHORT, JC_NONE,     ST_WAIT};
            ST_SHORT_SEL: w = '{DP_SELECT, UNIT_SHORT, JC_NONE,     ST_WAIT};
            ST_SHORT_MUL: w = '{DP_MUL,    UNIT_SHORT, JC_NONE,     ST_WAIT};
            ST_SHORT_ACC: w = '{DP_ACC,    UNIT_SHORT, JC_LOOP,     ST_SHORT_MUL};
            ST_SHORT_APP: w = '{DP_APPLY,  UNIT_SHORT, JC_NONE,     ST_WAIT};
            ST_LONG_SEL:  w = '{DP_SELECT, UNIT_LONG,  JC_NONE,     ST_WAIT};
            ST_LONG_MUL:  w = '{DP_MUL,    UNIT_LONG,  JC_NONE,     ST_WAIT};
            ST_LONG_ACC:  w = '{DP_ACC,    UNIT_LONG,  JC_LOOP,     ST_LONG_MUL};
            ST_LONG_APP:  w = '{DP_APPLY,  UNIT_LONG,  JC_NONE,     ST_WAIT};
            ST_PEAK_SEL:  w = '{DP_SELECT, UNIT_PEAK,  JC_NONE,     ST_WAIT};
            ST_PEAK_MUL:  w = '{DP_MUL,    UNIT_PEAK,  JC_NONE,     ST_WAIT};
            ST_PEAK_ACC:  w = '{DP_ACC,    UNIT_PEAK,  JC_LOOP,     ST_PEAK_MUL};
            ST_PEAK_APP:  w = '{DP_APPLY,  UNIT_PEAK,  JC_NONE,     ST_WAIT};
            ST_HOLD_SEL:  w = '{DP_SELECT, UNIT_HOLD,  JC_NONE,     ST_WAIT};
            ST_HOLD_MUL:  w = '{DP_MUL,    UNIT_HOLD,  JC_NONE,     ST_WAIT};
            ST_HOLD_ACC:  w = '{DP_ACC,    UNIT_HOLD,  JC_LOOP,     ST_HOLD_MUL};
            ST_HOLD_APP:  w = '{DP_APPLY,  UNIT_HOLD,  JC_NONE,     ST_WAIT};
            ST_EMIT:      w = '{DP_EMIT,   UNIT_SHORT, JC_OUT_BUSY, ST_EMIT};
            default:      w = '{DP_LOAD,   UNIT_SHORT, JC_NO_INPUT, ST_WAIT};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0]  pc_reg;
    logic [PC_W-1:0]  pc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    uinstr_t          cur;
    logic             taken;

    assign cur = rom(pc_reg);

    always_comb
    begin
        ctrl.op   = cur.op;
        ctrl.unit = cur.unit;
        case (cur.op)
            DP_LOAD: ctrl.go = sample_valid;
            DP_EMIT: ctrl.go = !result_busy;
            default: ctrl.go = 1'b1;
        endcase
    end

    always_comb
    begin
        case (cur.jc)
            JC_NO_INPUT: taken = !sample_valid;
            JC_LOOP:     taken = (cnt_reg != CNT_W'(1));
            JC_OUT_BUSY: taken = result_busy;
            default:     taken = 1'b0;
        endcase
        if (taken)
            pc_next = cur.target;
        else if (pc_reg == ST_EMIT)
            pc_next = ST_WAIT;
        else
            pc_next = pc_reg + PC_W'(1);
    end

    always_comb
    begin
        case (cur.op)
            DP_SELECT: cnt_next = CNT_W'(NUM_CHUNKS);
            DP_ACC:    cnt_next = cnt_reg - CNT_W'(1);
            default:   cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= ST_WAIT;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (cur.op == DP_ACC && cnt_reg == CNT_W'(1)) |=> (cur.op == DP_APPLY))
        else $error("chunk loop did not exit to apply step");

    a_loop_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cur.op == DP_SELECT) |=> (cnt_reg == CNT_W'(NUM_CHUNKS) && cur.op == DP_MUL))
        else $error("chunk counter not loaded on select");

    a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cur.op == DP_EMIT && result_busy) |=> (cur.op == DP_EMIT))
        else $error("emit step left while result word waits");

endmodule

`default_nettype wire

[hdl/alm_datapath.sv]
`default_nettype none

module alm_datapath #(
    parameter int SAMPLE_WIDTH = alm_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = alm_pkg::DEF_COEF_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample,
    input  wire alm_pkg::cfg_t                       cfg,
    input  wire alm_pkg::ctrl_t                      ctrl,
    input  wire logic                                result_ready,
    output logic                                     result_busy,
    output logic                                     result_valid,
    output logic [2*(SAMPLE_WIDTH-1)-1:0]            short_mean_square,
    output logic [2*(SAMPLE_WIDTH-1)-1:0]            long_mean_square,
    output logic [SAMPLE_WIDTH-1:0]                  peak_level,
    output logic [SAMPLE_WIDTH-1:0]                  hold_level,
    output logic [alm_pkg::COUNT_W-1:0]              clip_count,
    output logic [alm_pkg::COUNT_W-1:0]              sample_count
);
    import alm_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int MS_W  = 2 * (SW - 1);
    localparam int AVG_W = MS_W + MS_GUARD;
    localparam int LVL_W = SW + LV_GUARD;
    localparam int NCH   = (AVG_W + CW - 1) / CW;
    localparam int D_W   = NCH * CW;
    localparam int ACC_W = D_W + CW;
    localparam int MUL_W = (SW > CW) ? SW : CW;
    localparam int CMP_W = (SW > CLIP_LEVEL_W) ? SW : CLIP_LEVEL_W;

    logic [AVG_W-1:0]       short_avg_reg;
    logic [AVG_W-1:0]       long_avg_reg;
    logic [LVL_W-1:0]       peak_reg;
    logic [LVL_W-1:0]       hold_reg;
    logic [HOLD_TIME_W-1:0] hold_counter_reg;
    logic [COUNT_W-1:0]     clipped_reg;
    logic [COUNT_W-1:0]     seen_reg;
    logic                   out_valid_reg;

    logic [SW-1:0]          mag_reg;
    logic [AVG_W-1:0]       sq_reg;
    logic                   hold_dec_reg;
    logic                   dir_reg;
    logic [D_W-1:0]         diff_reg;
    logic [2*CW-1:0]        prod_reg;
    logic [ACC_W-1:0]       acc_reg;

    logic [MS_W-1:0]        short_ms_reg;
    logic [MS_W-1:0]        long_ms_reg;
    logic [SW-1:0]          peak_out_reg;
    logic [SW-1:0]          hold_out_reg;
    logic [COUNT_W-1:0]     clip_out_reg;
    logic [COUNT_W-1:0]     seen_out_reg;

    logic [SW-1:0]          mag_in;
    logic [LVL_W-1:0]       lvl_in;
    logic [LVL_W-1:0]       lvl_cur;
    logic [AVG_W-1:0]       x_sel;
    logic [AVG_W-1:0]       t_sel;
    logic [AVG_W:0]         up;
    logic [AVG_W-1:0]       dn;
    logic [CW-1:0]          coef_sel;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [2*MUL_W-1:0]     product;
    logic [AVG_W-1:0]       step;
    logic [AVG_W-1:0]       x_new;
    logic                   load_go;
    logic                   emit_go;
    logic                   apply_go;

    assign mag_in   = sample[SW-1] ? (~sample + SW'(1)) : sample;
    assign lvl_in   = LVL_W'(mag_in) << LV_GUARD;
    assign lvl_cur  = LVL_W'(mag_reg) << LV_GUARD;
    assign load_go  = (ctrl.op == DP_LOAD) && ctrl.go;
    assign emit_go  = (ctrl.op == DP_EMIT) && ctrl.go;
    assign apply_go = (ctrl.op == DP_APPLY);
    assign result_busy = out_valid_reg && !result_ready;

    always_comb
    begin
        case (ctrl.unit)
            UNIT_SHORT:
            begin
                x_sel    = short_avg_reg;
                t_sel    = sq_reg;
                coef_sel = cfg.short_coef[31 -: CW];
            end
            UNIT_LONG:
            begin
                x_sel    = long_avg_reg;
                t_sel    = sq_reg;
                coef_sel = cfg.long_coef[31 -: CW];
            end
            UNIT_PEAK:
            begin
                x_sel    = AVG_W'(peak_reg);
                t_sel    = AVG_W'(lvl_cur);
                coef_sel = cfg.peak_coef[31 -: CW];
            end
            default:
            begin
                x_sel    = AVG_W'(hold_reg);
                t_sel    = '0;
                coef_sel = cfg.hold_decay_coef[31 -: CW];
            end
        endcase
    end

    assign up = {1'b0, t_sel} - {1'b0, x_sel};
    assign dn = x_sel - t_sel;

    // one shared multiplier: squaring or chunk times coefficient
    always_comb
    begin
        if (ctrl.op == DP_SQUARE)
        begin
            mul_a = MUL_W'(mag_reg);
            mul_b = MUL_W'(mag_reg);
        end
        else
        begin
            mul_a = MUL_W'(diff_reg[D_W-1 -: CW]);
            mul_b = MUL_W'(coef_sel);
        end
    end

    assign product = mul_a * mul_b;
    assign step    = acc_reg[CW +: AVG_W];
    assign x_new   = dir_reg ? (x_sel + step) : (x_sel - step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_avg_reg    <= '0;
            long_avg_reg     <= '0;
            peak_reg         <= '0;
            hold_reg         <= '0;
            hold_counter_reg <= '0;
            clipped_reg      <= '0;
            seen_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (load_go)
            begin
                if (seen_reg != '1)
                    seen_reg <= seen_reg + COUNT_W'(1);
                if (CMP_W'(mag_in) >= CMP_W'(cfg.clip_level) && clipped_reg != '1)
                    clipped_reg <= clipped_reg + COUNT_W'(1);
                if (hold_reg < lvl_in)
                begin
                    hold_reg         <= lvl_in;
                    hold_counter_reg <= cfg.hold_time;
                end
                else if (hold_counter_reg != '0)
                    hold_counter_reg <= hold_counter_reg - HOLD_TIME_W'(1);
                if (!(peak_reg > lvl_in))
                    peak_reg <= lvl_in;
            end
            if (apply_go)
            begin
                case (ctrl.unit)
                    UNIT_SHORT: short_avg_reg <= x_new;
                    UNIT_LONG:  long_avg_reg  <= x_new;
                    UNIT_PEAK:  peak_reg      <= x_new[LVL_W-1:0];
                    default:
                    begin
                        if (hold_dec_reg)
                            hold_reg <= x_new[LVL_W-1:0];
                    end
                endcase
            end
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            DP_LOAD:
            begin
                if (ctrl.go)
                begin
                    mag_reg      <= mag_in;
                    hold_dec_reg <= !(hold_reg < lvl_in) && (hold_counter_reg == '0);
                end
            end
            DP_SQUARE:
            begin
                // full-scale magnitude squares past the top code
                if (mag_reg[SW-1])
                    sq_reg <= AVG_W'({MS_W{1'b1}}) << MS_GUARD;
                else
                    sq_reg <= AVG_W'(product[MS_W-1:0]) << MS_GUARD;
            end
            DP_SELECT:
            begin
                dir_reg  <= !up[AVG_W];
                diff_reg <= up[AVG_W] ? D_W'(dn) : D_W'(up[AVG_W-1:0]);
                acc_reg  <= '0;
            end
            DP_MUL:
            begin
                prod_reg <= product[2*CW-1:0];
                diff_reg <= diff_reg << CW;
            end
            DP_ACC:
            begin
                acc_reg <= (acc_reg << CW) + ACC_W'(prod_reg);
            end
            DP_EMIT:
            begin
                if (ctrl.go)
                begin
                    short_ms_reg <= short_avg_reg[MS_GUARD +: MS_W];
                    long_ms_reg  <= long_avg_reg[MS_GUARD +: MS_W];
                    peak_out_reg <= peak_reg[LV_GUARD +: SW];
                    hold_out_reg <= hold_reg[LV_GUARD +: SW];
                    clip_out_reg <= clipped_reg;
                    seen_out_reg <= seen_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign result_valid      = out_valid_reg;
    assign short_mean_square = short_ms_reg;
    assign long_mean_square  = long_ms_reg;
    assign peak_level        = peak_out_reg;
    assign hold_level        = hold_out_reg;
    assign clip_count        = clip_out_reg;
    assign sample_count      = seen_out_reg;

    a_seen_moves: assert property (@(posedge clk) disable iff (!rst_n)
        load_go |=> (seen_reg != '0))
        else $error("sample counter did not advance");

    a_hold_decay: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_go && ctrl.unit == UNIT_HOLD) |=> (hold_reg <= $past(hold_reg)))
        else $error("hold decay raised the hold value");

    a_peak_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_go && ctrl.unit == UNIT_PEAK) |=> (peak_reg >= lvl_cur))
        else $error("peak decayed past the magnitude");

endmodule

`default_nettype wire

[hdl/audio_level_meter_top.sv]
// each sample word: load, square, per smoother select, N multiply and accumulate chunks, apply, emit
// no new sample word is taken until the emit step, N = ceil((2*SAMPLE_WIDTH + 8) / COEF_WIDTH)
// the four smoothers share one multiplier, N chunks per smoother
// a waiting result word holds the emit step and so blocks the next sample word
// rst_n is asynchronous active low: levels, counters and sequencer clear, registers take defaults
`default_nettype none

module audio_level_meter_top #(
    parameter int SAMPLE_WIDTH = alm_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = alm_pkg::DEF_COEF_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [alm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [alm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [alm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready,
    input  wire logic                              sample_valid,
    output logic                                   sample_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    sample,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [2*(SAMPLE_WIDTH-1)-1:0]          short_mean_square,
    output logic [2*(SAMPLE_WIDTH-1)-1:0]          long_mean_square,
    output logic [SAMPLE_WIDTH-1:0]                peak_level,
    output logic [SAMPLE_WIDTH-1:0]                hold_level,
    output logic [alm_pkg::COUNT_W-1:0]            clip_count,
    output logic [alm_pkg::COUNT_W-1:0]            sample_count
);
    import alm_pkg::*;

    localparam int AVG_W = 2 * (SAMPLE_WIDTH - 1) + MS_GUARD;
    localparam int NCH   = (AVG_W + COEF_WIDTH - 1) / COEF_WIDTH;

    cfg_t  cfg;
    ctrl_t ctrl;
    logic  result_busy;

    assign sample_ready = (ctrl.op == DP_LOAD);

    alm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    alm_sequencer #(
        .NUM_CHUNKS (NCH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .result_busy  (result_busy),
        .ctrl         (ctrl)
    );

    alm_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample            (sample),
        .cfg               (cfg),
        .ctrl              (ctrl),
        .result_ready      (result_ready),
        .result_busy       (result_busy),
        .result_valid      (result_valid),
        .short_mean_square (short_mean_square),
        .long_mean_square  (long_mean_square),
        .peak_level        (peak_level),
        .hold_level        (hold_level),
        .clip_count        (clip_count),
        .sample_count      (sample_count)
    );

endmodule

`default_nettype wire
